>>> sv/flash_record_ring_slot_tracker_unit_defines.svh
// Assertion helpers for the record ring slot tracker.
`ifndef FLASH_RECORD_RING_SLOT_TRACKER_UNIT_DEFINES_SVH
`define FLASH_RECORD_RING_SLOT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FRST_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("frst: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FRST_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("frst: next-cycle check failed");

`endif

>>> sv/frst_pkg.sv
`default_nettype none

package frst_pkg;

    localparam int ADDR_W       = 24;
    localparam int SEQ_W        = 32;
    localparam int ADDR_EXT_W   = ADDR_W + 1;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;

    localparam logic [1:0] REQ_SCAN_FIRST = 2'd0;
    localparam logic [1:0] REQ_SCAN_NEXT  = 2'd1;
    localparam logic [1:0] REQ_SAVE       = 2'd2;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_END   = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SEQ_W-1:0]  seq_t;

    typedef enum logic [1:0] {
        ST_SCAN   = 2'd0,
        ST_FOUND  = 2'd1,
        ST_REINIT = 2'd2,
        ST_SAVED  = 2'd3
    } status_t;

    typedef struct packed {
        addr_t current_slot;
        seq_t  current_seq;
        addr_t scan_addr;
        seq_t  run_seq;
    } trk_state_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        addr_t   slot_addr;
        seq_t    seq;
        logic    erase_sector;
        logic    erase_region;
    } trk_result_t;

endpackage

`default_nettype wire

>>> sv/frst_core.sv
`default_nettype none

module frst_core #(
    parameter int PAGE_BYTES   = frst_pkg::PAGE_BYTES,
    parameter int SECTOR_BYTES = frst_pkg::SECTOR_BYTES
) (
    input  wire logic [1:0]         req_type,
    input  wire logic               id_ok,
    input  wire logic               crc_ok,
    input  wire frst_pkg::seq_t     page_seq,
    input  wire frst_pkg::addr_t    region_start,
    input  wire frst_pkg::addr_t    region_end,
    input  wire frst_pkg::trk_state_t state,
    output frst_pkg::trk_state_t    state_next,
    output frst_pkg::trk_result_t   result
);
    import frst_pkg::*;

    localparam int SECTOR_BITS = $clog2(SECTOR_BYTES);
    localparam logic [ADDR_EXT_W-1:0] PAGE_INC = (ADDR_EXT_W)'(PAGE_BYTES);

    logic [ADDR_EXT_W-1:0] end_ext;
    logic [ADDR_EXT_W-1:0] first_next;
    logic [ADDR_EXT_W-1:0] scan_next;
    logic [ADDR_EXT_W-1:0] save_next;
    seq_t                  run_inc;
    seq_t                  cur_inc;
    addr_t                 save_slot;
    logic                  do_reinit;

    assign end_ext    = {1'b0, region_end};
    assign first_next = {1'b0, region_start} + PAGE_INC;
    assign scan_next  = {1'b0, state.scan_addr} + PAGE_INC;
    assign save_next  = {1'b0, state.current_slot} + PAGE_INC;
    assign run_inc    = state.run_seq + seq_t'(1);
    assign cur_inc    = state.current_seq + seq_t'(1);
    assign save_slot  = (save_next >= end_ext) ? region_start : save_next[ADDR_W-1:0];

    always_comb
    begin
        state_next = state;
        result     = '0;
        do_reinit  = 1'b0;
        unique case (req_type)
            REQ_SCAN_FIRST:
            begin
                if (!id_ok || (first_next >= end_ext))
                begin
                    do_reinit = 1'b1;
                end
                else
                begin
                    state_next.run_seq   = page_seq;
                    state_next.scan_addr = first_next[ADDR_W-1:0];
                    result.valid         = 1'b1;
                    result.status        = ST_SCAN;
                    result.slot_addr     = first_next[ADDR_W-1:0];
                    result.seq           = page_seq;
                end
            end
            REQ_SCAN_NEXT:
            begin
                if (state.scan_addr >= region_end)
                begin
                    do_reinit = 1'b1;
                end
                else if (id_ok && crc_ok && (page_seq == run_inc))
                begin
                    if (scan_next >= end_ext)
                    begin
                        do_reinit = 1'b1;
                    end
                    else
                    begin
                        state_next.run_seq   = page_seq;
                        state_next.scan_addr = scan_next[ADDR_W-1:0];
                        result.valid         = 1'b1;
                        result.status        = ST_SCAN;
                        result.slot_addr     = scan_next[ADDR_W-1:0];
                        result.seq           = page_seq;
                    end
                end
                else
                begin
                    state_next.current_slot = state.scan_addr - addr_t'(PAGE_BYTES);
                    state_next.current_seq  = state.run_seq;
                    result.valid            = 1'b1;
                    result.status           = ST_FOUND;
                    result.slot_addr        = state.scan_addr - addr_t'(PAGE_BYTES);
                    result.seq              = state.run_seq;
                end
            end
            REQ_SAVE:
            begin
                state_next.current_slot = save_slot;
                state_next.current_seq  = cur_inc;
                result.valid            = 1'b1;
                result.status           = ST_SAVED;
                result.slot_addr        = save_slot;
                result.seq              = cur_inc;
                result.erase_sector     = (save_slot[SECTOR_BITS-1:0] == '0);
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase

        if (do_reinit)
        begin
            state_next.current_slot = region_start;
            state_next.current_seq  = '0;
            state_next.scan_addr    = region_start;
            state_next.run_seq      = '0;
            result.valid            = 1'b1;
            result.status           = ST_REINIT;
            result.slot_addr        = region_start;
            result.seq              = '0;
            result.erase_sector     = 1'b0;
            result.erase_region     = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/flash_record_ring_slot_tracker_unit.sv
// Record ring slot tracker for a wear-levelled flash settings log.
// Request channel (req_valid/req_stall): req_type, id_ok, crc_ok, page_seq.
//   Scan first page, then scan next pages one per transfer; save advances slot.
// Response channel (rsp_valid/rsp_stall): status, slot_addr, seq_out,
//   erase_sector, erase_region. One response per request; unused request
//   code 3 is consumed with no response.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
//   region start, 1 writes region end. Write only while the block is idle.
// Pipeline: request register, then response register. Throughput: one request
//   per cycle while rsp_stall is low; the state update is a single
//   compare/increment pass in frst_core.
// Receiver stall: the response register holds, and req_stall rises once the
//   request register is also full; no transfer is lost.
// Reset: region start 0, region end 16384, slot and scan position at region
//   start, sequences 0, both channels empty.
`default_nettype none

`include "flash_record_ring_slot_tracker_unit_defines.svh"

module flash_record_ring_slot_tracker_unit #(
    parameter int PAGE_BYTES   = frst_pkg::PAGE_BYTES,
    parameter int SECTOR_BYTES = frst_pkg::SECTOR_BYTES
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire logic [1:0]      req_type,
    input  wire logic            id_ok,
    input  wire logic            crc_ok,
    input  wire frst_pkg::seq_t  page_seq,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output logic [1:0]           status,
    output frst_pkg::addr_t      slot_addr,
    output frst_pkg::seq_t       seq_out,
    output logic                 erase_sector,
    output logic                 erase_region,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire frst_pkg::addr_t cfg_data
);
    import frst_pkg::*;

    addr_t       region_start_reg;
    addr_t       region_end_reg;
    trk_state_t  state_reg;
    trk_state_t  state_next;
    trk_result_t result;

    logic        req_valid_reg;
    logic [1:0]  req_type_reg;
    logic        id_ok_reg;
    logic        crc_ok_reg;
    seq_t        page_seq_reg;

    logic        rsp_valid_reg;
    trk_result_t rsp_reg;

    logic        req_take;
    logic        advance;
    logic        unused_drop;

    assign advance     = !rsp_valid_reg || !rsp_stall;
    assign req_stall   = req_valid_reg && !advance;
    assign req_take    = req_valid && !req_stall;
    assign cfg_ready   = 1'b1;
    assign unused_drop = req_valid_reg && advance && (req_type_reg == REQ_UNUSED);

    frst_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .req_type     (req_type_reg),
        .id_ok        (id_ok_reg),
        .crc_ok       (crc_ok_reg),
        .page_seq     (page_seq_reg),
        .region_start (region_start_reg),
        .region_end   (region_end_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= addr_t'(16384);
            state_reg        <= '0;
            req_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_REGION_START: region_start_reg <= cfg_data;
                    CFG_REGION_END:   region_end_reg   <= cfg_data;
                    default:          region_start_reg <= region_start_reg;
                endcase
            end
            if (advance || !req_valid_reg)
            begin
                req_valid_reg <= req_take;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg && result.valid;
            end
            if (req_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_type_reg <= req_type;
            id_ok_reg    <= id_ok;
            crc_ok_reg   <= crc_ok;
            page_seq_reg <= page_seq;
        end
        if (req_valid_reg && advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_reg.status;
    assign slot_addr    = rsp_reg.slot_addr;
    assign seq_out      = rsp_reg.seq;
    assign erase_sector = rsp_reg.erase_sector;
    assign erase_region = rsp_reg.erase_region;

    `FRST_ASSERT_IMPL(a_erase_region_is_reinit, clk, rst_n, rsp_valid && erase_region, status == ST_REINIT)
    `FRST_ASSERT_IMPL(a_erase_sector_on_save, clk, rst_n, rsp_valid && erase_sector, status == ST_SAVED)
    `FRST_ASSERT_NEXT(a_unused_code_silent, clk, rst_n, unused_drop, !rsp_valid)

endmodule

`default_nettype wire
